// ===== rtl/monotone_table_bisection_search_defines.svh =====
// Assertion macros for the checker file of the table search block.
// No dependencies; every macro expects i_clk and i_rst_n in scope.
`ifndef MONOTONE_TABLE_BISECTION_SEARCH_DEFINES_SVH
`define MONOTONE_TABLE_BISECTION_SEARCH_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define MTBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MTBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mtbs_pkg.sv =====
// Shared constants, codes and controller/datapath types of the table search block.
// No dependencies.
package mtbs_pkg;

    localparam int DEPTH   = 1024;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH) + 1;
    localparam int POS_W   = 10;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(DEPTH);

    // Input item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Read address selection
    localparam logic [1:0] RD_FIRST = 2'd0;
    localparam logic [1:0] RD_LAST  = 2'd1;
    localparam logic [1:0] RD_MID   = 2'd2;

    typedef struct packed {
        logic       wr_en;
        logic       load_query;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_first;
        logic       cap_dir;
        logic       step;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
        logic out_busy;
    } t_dp_status;

endpackage

// ===== rtl/mtbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Store on write, register read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/mtbs_dp.sv =====
// Datapath of the table search block: table RAM, bisection bounds, result register.
// Depends on mtbs_pkg and mtbs_ram.
module mtbs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mtbs_pkg::t_dp_cmd               i_cmd,
    output mtbs_pkg::t_dp_status            o_status,
    input  logic [mtbs_pkg::ADDR_W-1:0]     i_index,
    input  logic signed [mtbs_pkg::VALUE_W-1:0] i_value,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mtbs_pkg::COUNT_W-1:0]    i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mtbs_pkg::POS_W-1:0]      o_position
);
    import mtbs_pkg::*;

    logic [COUNT_W-1:0]        r_cfg_count;
    logic [COUNT_W-1:0]        used_count;
    logic signed [VALUE_W-1:0] r_key;
    logic signed [VALUE_W-1:0] r_first;
    logic [COUNT_W-1:0]        r_n;
    logic [COUNT_W-1:0]        r_lo;
    logic [COUNT_W-1:0]        r_hi;
    logic [ADDR_W-1:0]         r_mid;
    logic                      r_asc;
    logic                      r_o_valid;
    logic [POS_W-1:0]          r_pos;
    logic [VALUE_W-1:0]        rd_data;
    logic signed [VALUE_W-1:0] entry;
    logic                      go_right;
    logic [COUNT_W-1:0]        lo_nx;
    logic [COUNT_W-1:0]        hi_nx;
    logic [COUNT_W:0]          mid_sum;
    logic [COUNT_W-1:0]        mid_nx;
    logic [COUNT_W-1:0]        last_idx;
    logic [ADDR_W-1:0]         rd_addr;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_cfg_count <= i_cfg_data;
        end
    end

    // Clamp the entry count to 1..DEPTH
    always_comb begin
        used_count = r_cfg_count;
        if (r_cfg_count == '0) begin
            used_count = COUNT_W'(1);
        end else if (r_cfg_count > COUNT_W'(DEPTH)) begin
            used_count = COUNT_W'(DEPTH);
        end
    end

    assign entry    = $signed(rd_data);
    assign go_right = ((r_key >= entry) == r_asc);

    // Next bounds: narrow around the entry just read, or hold
    always_comb begin
        lo_nx = r_lo;
        hi_nx = r_hi;
        if (i_cmd.step) begin
            if (go_right) begin
                lo_nx = COUNT_W'(r_mid);
            end else begin
                hi_nx = COUNT_W'(r_mid);
            end
        end
    end

    assign mid_sum  = {1'b0, lo_nx} + {1'b0, hi_nx};
    assign mid_nx   = mid_sum[COUNT_W:1];
    assign last_idx = r_n - COUNT_W'(1);

    assign o_status.more     = ((hi_nx - lo_nx) > COUNT_W'(1));
    assign o_status.out_busy = r_o_valid && !i_ready;

    // Select the table read address
    always_comb begin
        case (i_cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = last_idx[ADDR_W-1:0];
            RD_MID:   rd_addr = mid_nx[ADDR_W-1:0];
            default:  rd_addr = '0;
        endcase
    end

    mtbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_index),
        .i_wr_data (i_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Query registers: key, bounds, end entries, direction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_key <= i_value;
            r_n   <= used_count;
            r_lo  <= '0;
            r_hi  <= used_count;
        end else begin
            r_lo <= lo_nx;
            r_hi <= hi_nx;
        end
        if (i_cmd.rd_en && (i_cmd.rd_sel == RD_MID)) begin
            r_mid <= mid_nx[ADDR_W-1:0];
        end
        if (i_cmd.cap_first) begin
            r_first <= entry;
        end
        if (i_cmd.cap_dir) begin
            r_asc <= (entry >= r_first);
        end
        if (i_cmd.out_load) begin
            r_pos <= r_lo[POS_W-1:0];
        end
    end

    // Result valid: set on load, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_position = r_pos;

endmodule

// ===== rtl/mtbs_ctrl.sv =====
// Controller state machine of the table search block.
// Depends on mtbs_pkg.
module mtbs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  mtbs_pkg::t_dp_status i_status,
    output mtbs_pkg::t_dp_cmd    o_cmd
);
    import mtbs_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD_FIRST = 3'd1;
    localparam logic [2:0] S_RD_LAST  = 3'd2;
    localparam logic [2:0] S_DIR      = 3'd3;
    localparam logic [2:0] S_STEP     = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // Sequence one item: write at once, or read ends then bisect
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        n_state          = S_RD_FIRST;
                    end
                end
            end
            S_RD_FIRST: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_FIRST;
                n_state      = S_RD_LAST;
            end
            S_RD_LAST: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = RD_LAST;
                o_cmd.cap_first = 1'b1;
                n_state         = S_DIR;
            end
            S_DIR: begin
                o_cmd.cap_dir = 1'b1;
                o_cmd.rd_sel  = RD_MID;
                if (i_status.more) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_STEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_STEP: begin
                o_cmd.step   = 1'b1;
                o_cmd.rd_sel = RD_MID;
                if (i_status.more) begin
                    o_cmd.rd_en = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/monotone_table_bisection_search.sv =====
// Top level of the ordered-table bisection search block.
// Depends on mtbs_pkg, mtbs_ctrl and mtbs_dp.
//
// Keeps a 1024-entry table of signed Q16.16 values and, for a query key, returns
// the lower bracketing index within the first entry_count entries, for tables
// ordered either way (direction from the last used entry against the first).
// A write item is done in idle and gives no result. A query runs at most
// ceil(log2(entry_count)) bisection steps; from its transfer until the next item
// can be taken, it reads the first and last entries in turn through the single
// table read port, settles the direction, does one read-and-compare per step,
// loads the result register and goes back to idle to take the next item. A
// finished result waits in that register while the next item is taken; a later
// query holds its result load, and with it the input, until that register is
// free. entry_count may be written only while the block is idle.
module monotone_table_bisection_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic [9:0]                          i_index,
    input  logic signed [mtbs_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mtbs_pkg::COUNT_W-1:0]        i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mtbs_pkg::POS_W-1:0]          o_position
);
    import mtbs_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mtbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_cmd),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    mtbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_index     (i_index[ADDR_W-1:0]),
        .i_value     (i_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_position  (o_position)
    );

endmodule

// ===== rtl/mtbs_chk.sv =====
// Port-level checker for the table search block, bound to the top level.
// Depends on mtbs_pkg and monotone_table_bisection_search_defines.svh.
`include "monotone_table_bisection_search_defines.svh"

module mtbs_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                i_cmd,
    input logic [9:0]                          i_index,
    input logic signed [mtbs_pkg::VALUE_W-1:0] i_value,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [mtbs_pkg::COUNT_W-1:0]        i_cfg_data,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [mtbs_pkg::POS_W-1:0]          o_position
);
    import mtbs_pkg::*;

    // Hold a stalled result
    `MTBS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_position), "stalled result changed")

    // The block is ready again in the cycle after a write transfer
    `MTBS_ASSERT_NEXT(a_write_one_cycle, i_valid && o_ready && (i_cmd == CMD_WRITE), o_ready, "write did not finish in one cycle")

    // A query transfer occupies the block
    `MTBS_ASSERT_NEXT(a_query_busy, i_valid && o_ready && (i_cmd == CMD_QUERY), !o_ready, "block ready right after query")

    // A new result appears as the block returns to ready
    `MTBS_ASSERT_SAME(a_result_ready, $rose(o_valid), o_ready, "result appeared while block busy")

endmodule

bind monotone_table_bisection_search mtbs_chk u_chk (.*);
